// ===== rtl/core/bffa_pkg.sv =====
// Package for the bitmap first-free allocator.
// Holds sizes, field widths, state codes and the memory write bundle.
// No dependencies.
`default_nettype none

package bffa_pkg;

    localparam int ENTRIES    = 4096;
    localparam int WORD_BITS  = 32;
    localparam int WORDS      = ENTRIES / WORD_BITS;
    localparam int WADDR_W    = $clog2(WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int IDX_W      = 12;
    localparam int LIM_W      = 13;
    localparam int NWORD_W    = WADDR_W + 1;
    localparam int CNT_W      = 4;
    localparam int MAX_RUN    = 12;
    localparam int ADDR_W     = 32;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 2;
    localparam int CFG_IDX_W  = 1;

    localparam logic       OP_ALLOC     = 1'b0;
    localparam logic       OP_LOAD      = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_BASE = 1'b1;

    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_FIND = 4'b0100,
        S_FAIL = 4'b1000
    } t_state;

    typedef struct packed {
        logic                 en;
        logic [WADDR_W-1:0]   addr;
        logic [WORD_BITS-1:0] data;
    } t_ram_wr;

endpackage

`default_nettype wire

// ===== rtl/core/bffa_bitmap_ram.sv =====
// Usage bitmap storage: one-port-write, one-port-read word memory.
// Per-word valid flags make unwritten words read as all zero after reset.
// Depends on bffa_pkg.
`default_nettype none

module bffa_bitmap_ram
    import bffa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_ram_wr              i_wr,
    input  wire logic                 i_rd_en,
    input  wire logic [WADDR_W-1:0]   i_rd_addr,
    output logic [WORD_BITS-1:0]      o_rd_data
);

    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORDS-1:0]     r_vld;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_first_free_allocator_top.sv =====
// Top level of the bitmap first-free allocator.
// Scan sequencer, configuration registers and result register; uses
// bffa_pkg and bffa_bitmap_ram.
//
//   channel   | direction | handshake                | payload
//   s_axis    | in        | i_s_axis_tvalid/o_tready | tuser op, tdata count/word
//   m_axis    | out       | o_m_axis_tvalid/i_tready | tuser found/status, tdata, tlast
//   cfg       | in        | i_cfg_valid/o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A load writes its word from the idle state. An allocate reads each bitmap word scanned
// (memory read, then search) and emits one entry per cycle while the result register
// can take it, and ends with an exhaustion result if too few entries are free.
// The bitmap word memory has one registered read port.
// A stalled result register holds the search; reset makes every word read as all zero.
`default_nettype none

module bitmap_first_free_allocator_top
    import bffa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [3:0] request_count, [10:4] word_index, [42:11] word_value, zero fill
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] op
    input  wire logic                  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [11:0] entry_index, [43:12] entry_address, zero fill
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    // [0] found, [1] status
    output logic [OUT_USER_W-1:0]      o_m_axis_tuser,
    output logic                       o_m_axis_tlast,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ADDR_W-1:0]     i_cfg_data
);

    t_state                r_state, n_state;
    logic [WADDR_W-1:0]    r_widx, n_widx;
    logic [CNT_W-1:0]      r_want, n_want;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [WORD_BITS-1:0]  r_word, n_word;
    logic                  r_first, n_first;
    logic                  r_dirty, n_dirty;
    logic [LIM_W-1:0]      r_lim;
    logic [ADDR_W-1:0]     r_base;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;
    logic                  r_out_last;

    t_ram_wr               ram_wr;
    logic                  rd_en;
    logic [WORD_BITS-1:0]  rd_data;

    logic                  in_acc;
    logic                  in_op;
    logic [CNT_W-1:0]      in_count;
    logic [CNT_W-1:0]      in_want;
    logic [WADDR_W-1:0]    in_widx;
    logic [WORD_BITS-1:0]  in_wval;
    logic [LIM_W-1:0]      lim_c;
    logic [LIM_W-1:0]      lim_up;
    logic [NWORD_W-1:0]    nwords;
    logic                  last_word;
    logic [LIM_W-1:0]      word_end;
    logic [WORD_BITS-1:0]  mask;
    logic [WORD_BITS-1:0]  cur;
    logic [WORD_BITS-1:0]  free_bits;
    logic                  has_free;
    logic [BIT_W-1:0]      pos;
    logic [WORD_BITS-1:0]  cur_set;
    logic [IDX_W-1:0]      hit_idx;
    logic                  out_free;
    logic                  emit;
    logic [OUT_DATA_W-1:0] emit_data;
    logic [OUT_USER_W-1:0] emit_user;
    logic                  emit_last;

    bffa_bitmap_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (ram_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_widx),
        .o_rd_data (rd_data)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign in_op           = i_s_axis_tuser;
    assign in_count        = i_s_axis_tdata[3:0];
    assign in_widx         = i_s_axis_tdata[10:4];
    assign in_wval         = i_s_axis_tdata[42:11];
    assign in_want         = (in_count > CNT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : in_count;

    assign lim_c     = (r_lim > LIMIT_RESET) ? LIMIT_RESET : r_lim;
    assign lim_up    = lim_c + LIM_W'(WORD_BITS - 1);
    assign nwords    = lim_up[LIM_W-1:BIT_W];
    assign last_word = ({1'b0, r_widx} + NWORD_W'(1)) >= nwords;
    assign word_end  = {1'b0, r_widx, {BIT_W{1'b0}}} + LIM_W'(WORD_BITS);
    assign mask      = (word_end <= lim_c) ? '1
                     : ((WORD_BITS'(1) << lim_c[BIT_W-1:0]) - WORD_BITS'(1));

    assign cur       = r_first ? rd_data : r_word;
    assign free_bits = ~cur & mask;
    assign has_free  = |free_bits;

    always_comb begin
        pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                pos = BIT_W'(b);
            end
        end
    end

    assign cur_set  = cur | (WORD_BITS'(1) << pos);
    assign hit_idx  = {r_widx, pos};
    assign out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state   = r_state;
        n_widx    = r_widx;
        n_want    = r_want;
        n_cnt     = r_cnt;
        n_word    = r_word;
        n_first   = r_first;
        n_dirty   = r_dirty;
        rd_en     = 1'b0;
        ram_wr    = '{en: 1'b0, addr: r_widx, data: cur};
        emit      = 1'b0;
        emit_data = '0;
        emit_user = '0;
        emit_last = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (in_op == OP_LOAD) begin
                        ram_wr = '{en: 1'b1, addr: in_widx, data: in_wval};
                    end else if (in_want != '0) begin
                        n_want  = in_want;
                        n_cnt   = '0;
                        n_widx  = '0;
                        n_state = (nwords == '0) ? S_FAIL : S_RD;
                    end
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                n_first = 1'b1;
                n_dirty = 1'b0;
                n_state = S_FIND;
            end
            S_FIND: begin
                n_first = 1'b0;
                n_word  = cur;
                if (has_free) begin
                    if (out_free) begin
                        emit      = 1'b1;
                        emit_data = OUT_DATA_W'({r_base + ADDR_W'(hit_idx), hit_idx});
                        emit_user = 2'b01;
                        emit_last = (r_cnt + CNT_W'(1)) == r_want;
                        n_word    = cur_set;
                        n_dirty   = 1'b1;
                        n_cnt     = r_cnt + CNT_W'(1);
                        if (emit_last) begin
                            ram_wr  = '{en: 1'b1, addr: r_widx, data: cur_set};
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    ram_wr.en = r_dirty;
                    if (last_word) begin
                        n_state = S_FAIL;
                    end else begin
                        n_widx  = r_widx + WADDR_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_FAIL: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_user = 2'b10;
                    emit_last = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_lim       <= LIMIT_RESET;
            r_base      <= '0;
            r_first     <= 1'b0;
            r_dirty     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
            r_dirty <= n_dirty;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ENTRY_LIMIT:  r_lim  <= i_cfg_data[LIM_W-1:0];
                    CFG_ADDRESS_BASE: r_base <= i_cfg_data;
                    default: begin
                        r_lim <= r_lim;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_widx <= n_widx;
        r_want <= n_want;
        r_cnt  <= n_cnt;
        r_word <= n_word;
        if (emit) begin
            r_out_data <= emit_data;
            r_out_user <= emit_user;
            r_out_last <= emit_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/bffa_checker.sv =====
// Port-level checker for the bitmap first-free allocator, with its bind.
// Depends on bffa_pkg and bitmap_first_free_allocator_top.
`default_nettype none

module bffa_checker
    import bffa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  wire logic [OUT_USER_W-1:0] o_m_axis_tuser,
    input  wire logic                  o_m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    a_fail_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |->
            o_m_axis_tuser[1] && o_m_axis_tlast && (o_m_axis_tdata == '0))
        else $error("exhaustion result malformed");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> !o_m_axis_tuser[1])
        else $error("found result flagged as exhausted");

    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tuser[0] && !o_m_axis_tlast
        ##1 o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tdata[IDX_W-1:0] > $past(o_m_axis_tdata[IDX_W-1:0]))
        else $error("entries of one request not ascending");

endmodule

bind bitmap_first_free_allocator_top bffa_checker u_bffa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire
